[rtl/hkim_pkg.sv]
package hkim_pkg;

	localparam int unsigned ResW = 5;
	localparam int unsigned ProdW = 10;
	localparam int unsigned SumW = 11;
	localparam logic [ResW-1:0] Modulus = 5'd26;
	localparam logic [SumW-1:0] CofBias = 11'd650;
	localparam logic [11:0] Recip26 = 12'd2521;
	localparam int unsigned RecipShift = 16;

	typedef struct packed {
		logic [ResW-1:0] key_r0c0;
		logic [ResW-1:0] key_r0c1;
		logic [ResW-1:0] key_r0c2;
		logic [ResW-1:0] key_r1c0;
		logic [ResW-1:0] key_r1c1;
		logic [ResW-1:0] key_r1c2;
		logic [ResW-1:0] key_r2c0;
		logic [ResW-1:0] key_r2c1;
		logic [ResW-1:0] key_r2c2;
	} key_t;

	typedef struct packed {
		logic [ResW-1:0] inv_r0c0;
		logic [ResW-1:0] inv_r0c1;
		logic [ResW-1:0] inv_r0c2;
		logic [ResW-1:0] inv_r1c0;
		logic [ResW-1:0] inv_r1c1;
		logic [ResW-1:0] inv_r1c2;
		logic [ResW-1:0] inv_r2c0;
		logic [ResW-1:0] inv_r2c1;
		logic [ResW-1:0] inv_r2c2;
		logic            invertible;
		logic [ResW-1:0] det_residue;
	} res_t;

	// Each cofactor is m[P0]*m[P1] - m[N0]*m[N1], signs folded in.
	localparam logic [3:0] CofP0 [9] = '{4'd4, 4'd6, 4'd3, 4'd7, 4'd0, 4'd6, 4'd1, 4'd3, 4'd0};
	localparam logic [3:0] CofP1 [9] = '{4'd8, 4'd5, 4'd7, 4'd2, 4'd8, 4'd1, 4'd5, 4'd2, 4'd4};
	localparam logic [3:0] CofN0 [9] = '{4'd7, 4'd3, 4'd6, 4'd1, 4'd6, 4'd0, 4'd4, 4'd0, 4'd3};
	localparam logic [3:0] CofN1 [9] = '{4'd5, 4'd8, 4'd4, 4'd8, 4'd2, 4'd7, 4'd2, 4'd5, 4'd1};

	// Remainder by 26 through a reciprocal multiply, exact below 2048.
	function automatic logic [ResW-1:0] mod26(input logic [SumW-1:0] x);
		logic [RecipShift+SumW-1:0] prod;
		logic [SumW-1:0]  quot;
		logic [SumW+4:0]  back;
		logic [SumW-1:0]  rem;
		prod = {{RecipShift{1'b0}}, x} * {{(RecipShift+SumW-12){1'b0}}, Recip26};
		quot = prod[RecipShift +: SumW];
		back = quot * {{SumW{1'b0}}, Modulus};
		rem = x - back[SumW-1:0];
		return rem[ResW-1:0];
	endfunction

	function automatic logic [ResW-1:0] unit_inverse(input logic [ResW-1:0] d);
		logic [ResW-1:0] r;
		unique case (d)
			5'd1:    r = 5'd1;
			5'd3:    r = 5'd9;
			5'd5:    r = 5'd21;
			5'd7:    r = 5'd15;
			5'd9:    r = 5'd3;
			5'd11:   r = 5'd19;
			5'd15:   r = 5'd7;
			5'd17:   r = 5'd23;
			5'd19:   r = 5'd11;
			5'd21:   r = 5'd5;
			5'd23:   r = 5'd17;
			5'd25:   r = 5'd25;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

endpackage

[rtl/hill_key_inverse_mod26.sv]
// Inverts a 3x3 Hill cipher key modulo 26. One key transaction can enter
// in every cycle while key_stall is low, and it passes through the seven
// register stages of the datapath in turn (entry reduction,
// cofactor products, cofactor reduction, determinant products, determinant
// reduction with the unit-inverse lookup, scaling products, final
// reduction). Entries of 26 to 31 are taken as the integers they encode.
// A non-invertible key gives invertible low and an all-zero matrix, while
// det_residue still reports the reduced determinant. A stall on a valid
// result freezes the whole pipeline and is passed back to key_stall.
module hill_key_inverse_mod26 (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           key_valid,
	output logic           key_stall,
	input  hkim_pkg::key_t key,
	output logic           res_valid,
	input  logic           res_stall,
	output hkim_pkg::res_t res
);
	import hkim_pkg::*;

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	logic [ResW-1:0]  m_in   [9];
	logic [ResW-1:0]  m_s1   [9];
	logic [ProdW-1:0] pp_s2  [9];
	logic [ProdW-1:0] pn_s2  [9];
	logic [ResW-1:0]  top_s2 [3];
	logic [ResW-1:0]  cof_s3 [9];
	logic [ResW-1:0]  top_s3 [3];
	logic [ResW-1:0]  cof_s4 [9];
	logic [ProdW-1:0] dp_s4  [3];
	logic [ResW-1:0]  cof_s5 [9];
	logic [ResW-1:0]  det_s5;
	logic [ResW-1:0]  inv_s5;
	logic [ProdW-1:0] sp_s6  [9];
	logic             unit_s6;
	logic [ResW-1:0]  det_s6;
	logic [ResW-1:0]  out_s7 [9];
	logic             unit_s7;
	logic [ResW-1:0]  det_s7;

	logic [SumW-1:0]  det_sum;

	assign adv = !(v_s7 && res_stall);
	assign key_stall = !adv;
	assign res_valid = v_s7;

	assign m_in[0] = key.key_r0c0;
	assign m_in[1] = key.key_r0c1;
	assign m_in[2] = key.key_r0c2;
	assign m_in[3] = key.key_r1c0;
	assign m_in[4] = key.key_r1c1;
	assign m_in[5] = key.key_r1c2;
	assign m_in[6] = key.key_r2c0;
	assign m_in[7] = key.key_r2c1;
	assign m_in[8] = key.key_r2c2;

	assign det_sum = {1'b0, dp_s4[0]} + {1'b0, dp_s4[1]} + {1'b0, dp_s4[2]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= key_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 9; i++) begin
				m_s1[i] <= (m_in[i] >= Modulus) ? m_in[i] - Modulus : m_in[i];
			end
			for (int i = 0; i < 9; i++) begin
				pp_s2[i] <= {{ResW{1'b0}}, m_s1[CofP0[i]]} * {{ResW{1'b0}}, m_s1[CofP1[i]]};
				pn_s2[i] <= {{ResW{1'b0}}, m_s1[CofN0[i]]} * {{ResW{1'b0}}, m_s1[CofN1[i]]};
			end
			for (int i = 0; i < 3; i++) begin
				top_s2[i] <= m_s1[i];
			end
			for (int i = 0; i < 9; i++) begin
				cof_s3[i] <= mod26({1'b0, pp_s2[i]} + CofBias - {1'b0, pn_s2[i]});
			end
			top_s3 <= top_s2;
			cof_s4 <= cof_s3;
			for (int i = 0; i < 3; i++) begin
				dp_s4[i] <= {{ResW{1'b0}}, top_s3[i]} * {{ResW{1'b0}}, cof_s3[i]};
			end
			cof_s5 <= cof_s4;
			det_s5 <= mod26(det_sum);
			inv_s5 <= unit_inverse(mod26(det_sum));
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					sp_s6[r*3+c] <= {{ResW{1'b0}}, cof_s5[c*3+r]} * {{ResW{1'b0}}, inv_s5};
				end
			end
			unit_s6 <= (inv_s5 != '0);
			det_s6 <= det_s5;
			for (int i = 0; i < 9; i++) begin
				out_s7[i] <= mod26({1'b0, sp_s6[i]});
			end
			unit_s7 <= unit_s6;
			det_s7 <= det_s6;
		end
	end

	assign res.inv_r0c0 = out_s7[0];
	assign res.inv_r0c1 = out_s7[1];
	assign res.inv_r0c2 = out_s7[2];
	assign res.inv_r1c0 = out_s7[3];
	assign res.inv_r1c1 = out_s7[4];
	assign res.inv_r1c2 = out_s7[5];
	assign res.inv_r2c0 = out_s7[6];
	assign res.inv_r2c1 = out_s7[7];
	assign res.inv_r2c2 = out_s7[8];
	assign res.invertible = unit_s7;
	assign res.det_residue = det_s7;

endmodule

[bench/tb_hill_key_inverse_mod26.sv]
`timescale 1ns / 1ps

module tb_hill_key_inverse_mod26;
	import hkim_pkg::*;

	localparam int CycleLimit = 200000;
	localparam int RandomKeys = 1030;

	class inverse_book;
		res_t pending[$];
		int errors;
		int checked;

		function int wrap26(int x);
			int r;
			r = x % 26;
			if (r < 0) r += 26;
			return r;
		endfunction

		function res_t predict_inverse(key_t k);
			int units[12] = '{1, 3, 5, 7, 9, 11, 15, 17, 19, 21, 23, 25};
			int m[9];
			int cof[9];
			int vals[9];
			int det, d, inv;
			bit unit;
			res_t r;
			m[0] = k.key_r0c0; m[1] = k.key_r0c1; m[2] = k.key_r0c2;
			m[3] = k.key_r1c0; m[4] = k.key_r1c1; m[5] = k.key_r1c2;
			m[6] = k.key_r2c0; m[7] = k.key_r2c1; m[8] = k.key_r2c2;
			det = m[0] * m[4] * m[8] + m[3] * m[7] * m[2] + m[6] * m[1] * m[5]
				- m[6] * m[4] * m[2] - m[0] * m[7] * m[5] - m[3] * m[1] * m[8];
			d = wrap26(det);
			unit = 0;
			inv = 0;
			foreach (units[i]) begin
				if (units[i] == d) unit = 1;
			end
			if (unit) begin
				foreach (units[i]) begin
					if (inv == 0 && wrap26(units[i] * d) == 1) inv = units[i];
				end
			end
			cof[0] = m[4] * m[8] - m[7] * m[5];
			cof[1] = -(m[3] * m[8] - m[6] * m[5]);
			cof[2] = m[3] * m[7] - m[6] * m[4];
			cof[3] = -(m[1] * m[8] - m[7] * m[2]);
			cof[4] = m[0] * m[8] - m[6] * m[2];
			cof[5] = -(m[0] * m[7] - m[6] * m[1]);
			cof[6] = m[1] * m[5] - m[4] * m[2];
			cof[7] = -(m[0] * m[5] - m[3] * m[2]);
			cof[8] = m[0] * m[4] - m[3] * m[1];
			for (int row = 0; row < 3; row++) begin
				for (int col = 0; col < 3; col++) begin
					vals[row * 3 + col] = unit ? wrap26(wrap26(cof[col * 3 + row]) * inv) : 0;
				end
			end
			r = '0;
			r.inv_r0c0 = vals[0][4:0];
			r.inv_r0c1 = vals[1][4:0];
			r.inv_r0c2 = vals[2][4:0];
			r.inv_r1c0 = vals[3][4:0];
			r.inv_r1c1 = vals[4][4:0];
			r.inv_r1c2 = vals[5][4:0];
			r.inv_r2c0 = vals[6][4:0];
			r.inv_r2c1 = vals[7][4:0];
			r.inv_r2c2 = vals[8][4:0];
			r.invertible = unit;
			r.det_residue = d[4:0];
			return r;
		endfunction

		function int field_of(res_t r, int idx);
			case (idx)
				0: return r.inv_r0c0;
				1: return r.inv_r0c1;
				2: return r.inv_r0c2;
				3: return r.inv_r1c0;
				4: return r.inv_r1c1;
				5: return r.inv_r1c2;
				6: return r.inv_r2c0;
				7: return r.inv_r2c1;
				8: return r.inv_r2c2;
				9: return r.invertible;
				default: return r.det_residue;
			endcase
		endfunction

		task report(string what, int got, int want);
			errors++;
			$display("[%0t] mismatch on result %0d, %s: got %0d, expected %0d",
				$realtime, checked, what, got, want);
		endtask

		function void note(key_t k);
			pending.push_back(predict_inverse(k));
		endfunction

		task check(res_t got);
			string names[11] = '{"inv_r0c0", "inv_r0c1", "inv_r0c2", "inv_r1c0", "inv_r1c1",
				"inv_r1c2", "inv_r2c0", "inv_r2c1", "inv_r2c2", "invertible", "det_residue"};
			res_t want;
			if (pending.size() == 0) begin
				report("unexpected transaction", 1, 0);
			end else begin
				want = pending.pop_front();
				for (int i = 0; i < 11; i++) begin
					if (field_of(got, i) != field_of(want, i))
						report(names[i], field_of(got, i), field_of(want, i));
				end
			end
			checked++;
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic key_valid = 1'b0;
	logic key_stall;
	key_t key = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;

	inverse_book book;
	int cycles = 0;
	int offered = 0;
	int stall_left = 0;
	bit held = 0;

	hill_key_inverse_mod26 uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_valid (key_valid),
		.key_stall (key_stall),
		.key       (key),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CycleLimit) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (res_valid && !res_stall) book.check(res);
		if (!held && book.checked >= 300) begin
			held = 1;
			stall_left = 120;
		end
		if (stall_left > 0) begin
			res_stall <= 1'b1;
			stall_left--;
		end else if ((cycles / 500) % 4 == 1) begin
			res_stall <= 1'b0;
		end else begin
			int roll;
			roll = $urandom_range(0, 99);
			if (roll < 70) begin
				res_stall <= 1'b0;
			end else if (roll < 95) begin
				res_stall <= 1'b1;
				stall_left = $urandom_range(0, 2);
			end else begin
				res_stall <= 1'b1;
				stall_left = $urandom_range(8, 25);
			end
		end
	end

	function int sender_gap(int idx);
		int roll;
		if (idx >= 280 && idx < 480) return 0;
		if ((idx / 150) % 3 == 2) return 0;
		roll = $urandom_range(0, 99);
		if (roll < 70) return 0;
		if (roll < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 30);
	endfunction

	function key_t key_from(int e[9]);
		key_t k;
		k.key_r0c0 = e[0][4:0]; k.key_r0c1 = e[1][4:0]; k.key_r0c2 = e[2][4:0];
		k.key_r1c0 = e[3][4:0]; k.key_r1c1 = e[4][4:0]; k.key_r1c2 = e[5][4:0];
		k.key_r2c0 = e[6][4:0]; k.key_r2c1 = e[7][4:0]; k.key_r2c2 = e[8][4:0];
		return k;
	endfunction

	function key_t random_key();
		int e[9];
		int style;
		style = $urandom_range(0, 9);
		foreach (e[i]) begin
			if (style == 0) e[i] = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 31) : 0;
			else if (style < 3) e[i] = $urandom_range(0, 31);
			else e[i] = $urandom_range(0, 25);
		end
		return key_from(e);
	endfunction

	task send_key(key_t k);
		int gap;
		gap = sender_gap(offered);
		if (gap > 0) begin
			key_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		key_valid <= 1'b1;
		key <= k;
		do @(posedge clk); while (key_stall);
		book.note(k);
		offered++;
	endtask

	initial begin
		int units[11] = '{3, 5, 7, 9, 11, 15, 17, 19, 21, 23, 25};
		int directed[12][9] = '{
			'{0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{25, 25, 25, 25, 25, 25, 25, 25, 25},
			'{31, 31, 31, 31, 31, 31, 31, 31, 31},
			'{1, 0, 0, 0, 1, 0, 0, 0, 1},
			'{6, 24, 1, 13, 16, 10, 20, 17, 15},
			'{2, 0, 0, 0, 1, 0, 0, 0, 1},
			'{13, 0, 0, 0, 1, 0, 0, 0, 1},
			'{26, 0, 0, 0, 1, 0, 0, 0, 1},
			'{2, 0, 0, 0, 13, 0, 0, 0, 1},
			'{21, 21, 21, 21, 21, 21, 21, 21, 21},
			'{10, 10, 10, 10, 10, 10, 10, 10, 10},
			'{0, 27, 0, 0, 0, 29, 30, 0, 0}
		};
		int e[9];
		book = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i]) begin
			foreach (e[j]) e[j] = directed[i][j];
			send_key(key_from(e));
		end
		foreach (units[i]) begin
			e = '{0, 0, 0, 0, 1, 0, 0, 0, 1};
			e[0] = units[i];
			send_key(key_from(e));
		end
		repeat (RandomKeys) send_key(random_key());
		key_valid <= 1'b0;
		while (book.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (book.errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
